[src/assert_macros.svh]
// Assertion helpers used by the RTL in set_assoc_cache_lru_sim.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, also live during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sacl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_FETCH  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  // Outcome of one set lookup
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[src/set_assoc_cache_lru_sim.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Signals                         Content
// s_axis    in   tvalid tready tdata[71:0]       one access: command, address
// m_axis    out  tvalid tready tdata[103:0]      flags and running totals
// cfg       in   cfg_we cfg_index cfg_data[5:0]  set bits, ways, block bits
//
// An access reads the set row from the tag memory on accept; in the lookup state the row
// is compared, the victim picked and the row written back once the output can take the item.
// An instruction fetch is accepted and gives no item.
// A full output register holds the lookup stage until m_axis takes the item.
// Synchronous reset clears the per-set valid flags at once; no clearing pass.

`include "assert_macros.svh"

module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] command, [65:2] address, [71:66] zero
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] was_hit, [1] was_miss, [2] was_eviction, [3] second_hit,
  // [35:4] total_hits, [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [3:0] SET_BITS_MAX = 4'(MAX_SET_BITS);

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp;
  } row_t;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state;

  logic [2:0] set_index_bits;
  logic [3:0] ways_in_use;
  logic [5:0] block_offset_bits;

  logic [STAMP_W-1:0] access_clock;
  logic [CNT_W-1:0]   hit_total;
  logic [CNT_W-1:0]   miss_total;
  logic [CNT_W-1:0]   evict_total;

  row_t                  mem [NUM_SETS];
  logic [NUM_SETS-1:0]   row_ok;
  row_t                  rd_row;
  logic                  rd_ok;
  logic [SET_W-1:0]      req_set;
  logic [ADDR_WIDTH-1:0] req_tag;
  logic                  req_modify;

  // Request decode
  cmd_t                  in_cmd;
  logic [ADDR_WIDTH-1:0] in_addr;
  logic [ADDR_WIDTH-1:0] blk_addr;
  logic [3:0]            sbits;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      in_set;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic                  in_acc;

  assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
  assign in_addr  = s_axis_tdata[2 +: ADDR_WIDTH];
  assign sbits    = ({1'b0, set_index_bits} > SET_BITS_MAX) ? SET_BITS_MAX
                                                            : {1'b0, set_index_bits};
  assign blk_addr = in_addr >> block_offset_bits;
  assign set_mask = SET_W'((64'd1 << sbits) - 64'd1);
  assign in_set   = SET_W'(blk_addr) & set_mask;
  assign in_tag   = blk_addr >> sbits;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Lookup on the row read when the access was accepted
  logic [MAX_WAYS-1:0]              use_mask;
  logic [MAX_WAYS-1:0]              vld_eff;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_eff;
  logic [WAY_W-1:0]                 lk_way;
  lookup_t                          lk;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      use_mask[w] = (w == 0) || (6'(w) < 6'(ways_in_use));
    end
    vld_eff   = rd_ok ? rd_row.valid : '0;
    stamp_eff = rd_ok ? rd_row.stamp : '0;
  end

  sacl_set_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .WAY_W      (WAY_W)
  ) u_lookup (
    .valid    (vld_eff),
    .tags     (rd_row.tag),
    .stamps   (stamp_eff),
    .use_mask (use_mask),
    .tag      (req_tag),
    .way      (lk_way),
    .res      (lk)
  );

  logic             finish;
  logic             wr_en;
  row_t             wr_row;
  logic [CNT_W-1:0] hits_first;
  logic [CNT_W-1:0] hits_next;
  logic [CNT_W-1:0] miss_next;
  logic [CNT_W-1:0] evict_next;

  assign finish = (state == S_LOOK) && (!m_axis_tvalid || m_axis_tready);
  assign wr_en  = finish;

  always_comb begin
    wr_row.valid         = vld_eff;
    wr_row.tag           = rd_row.tag;
    wr_row.stamp         = stamp_eff;
    wr_row.valid[lk_way] = 1'b1;
    wr_row.tag[lk_way]   = req_tag;
    wr_row.stamp[lk_way] = access_clock;
    hits_first = lk.hit ? sat_inc(hit_total) : hit_total;
    hits_next  = req_modify ? sat_inc(hits_first) : hits_first;
    miss_next  = lk.hit ? miss_total : sat_inc(miss_total);
    evict_next = lk.evict ? sat_inc(evict_total) : evict_total;
  end

  // Tag memory: one row per set, one read port, one write port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row <= mem[in_set];
    end
    if (wr_en) begin
      mem[req_set] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_ok <= row_ok[in_set];
      end
      if (wr_en) begin
        row_ok[req_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_set    <= in_set;
      req_tag    <= in_tag;
      req_modify <= (in_cmd == CMD_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= 3'd0;
      ways_in_use       <= 4'd1;
      block_offset_bits <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   set_index_bits    <= cfg_data[2:0];
        REG_WAYS:       ways_in_use       <= cfg_data[3:0];
        REG_BLOCK_BITS: block_offset_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      access_clock  <= '0;
      hit_total     <= '0;
      miss_total    <= '0;
      evict_total   <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !finish) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // A fetch is dropped on accept
          if (in_acc && in_cmd != CMD_FETCH) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (finish) begin
            state         <= S_IDLE;
            access_clock  <= access_clock + STAMP_W'(1);
            hit_total     <= hits_next;
            miss_total    <= miss_next;
            evict_total   <= evict_next;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'd0, evict_next, miss_next, hits_next,
                              req_modify, lk.evict, !lk.hit, lk.hit};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_access_to_look, clk, rst, (in_acc && in_cmd != CMD_FETCH) |=> (state == S_LOOK), "access did not enter lookup")
  `ASSERT_CLK(a_write_then_idle, clk, rst, wr_en |=> (state == S_IDLE && row_ok[$past(req_set)]), "write-back left set unmarked or stage busy")
  `ASSERT_CLK(a_hit_xor_miss, clk, rst, m_axis_tvalid |-> (m_axis_tdata[0] ^ m_axis_tdata[1]), "item is not exactly one of hit or miss")
  `ASSERT_CLK(a_evict_on_miss, clk, rst, (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1], "eviction without miss")
  `ASSERT_CLK(a_clock_steps, clk, rst, finish |=> (access_clock == $past(access_clock) + STAMP_W'(1)), "access clock did not advance")

endmodule

`default_nettype wire

[src/sacl_set_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

module sacl_set_lookup import sacl_pkg::*; #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  parameter int WAY_W      = 3
) (
  input  logic [MAX_WAYS-1:0]                 valid,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tags,
  input  logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamps,
  input  logic [MAX_WAYS-1:0]                 use_mask,
  input  logic [ADDR_WIDTH-1:0]               tag,
  output logic [WAY_W-1:0]                    way,
  output lookup_t                             res
);

  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] hitv;
  logic [MAX_WAYS-1:0] invv;
  logic [MAX_WAYS-1:0] lruv;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    inv_idx;
  logic [WAY_W-1:0]    lru_idx;

  always_comb begin
    vld  = valid & use_mask;
    hitv = '0;
    invv = '0;
    lruv = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hitv[w] = vld[w] && (tags[w] == tag);
      invv[w] = use_mask[w] && !vld[w];
      // Oldest way: strictly older than lower ways, no newer than higher ways
      lruv[w] = use_mask[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (use_mask[v] && v != w) begin
          if (v < w) begin
            if (!(stamps[w] < stamps[v])) lruv[w] = 1'b0;
          end else begin
            if (stamps[w] > stamps[v]) lruv[w] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) hit_idx = WAY_W'(w);
      if (invv[w]) inv_idx = WAY_W'(w);
      if (lruv[w]) lru_idx = WAY_W'(w);
    end
  end

  always_comb begin
    res.hit   = |hitv;
    res.evict = !(|hitv) && !(|invv);
    if (|hitv) begin
      way = hit_idx;
    end else if (|invv) begin
      way = inv_idx;
    end else begin
      way = lru_idx;
    end
  end

endmodule

`default_nettype wire
